// ----- rtl/lcdsb_pkg.sv -----
// lcdsb_pkg: shared constants and types for the LCD shadow buffer refresh block.
// Depends on nothing; used by lcd_shadow_buffer_refresh and its testbench.
package lcdsb_pkg;

  // display geometry defaults
  localparam int COLUMNS_DEF = 16;
  localparam int ROWS_DEF    = 2;

  // a refresh sends at most this many bytes, two per cell
  localparam int MAX_RESULTS   = 64;
  localparam int MAX_CELLS_OUT = MAX_RESULTS / 2;
  localparam int CNT_W         = $clog2(MAX_CELLS_OUT + 1);

  // cell byte fields and bus codes
  localparam logic [7:0] DIRTY_BIT  = 8'h80;
  localparam logic [7:0] CHAR_MASK  = 8'h7f;
  localparam logic [7:0] POS_ROW0   = 8'h80;
  localparam logic [7:0] POS_ROW1   = 8'hc0;
  localparam logic [7:0] CMD_CLEAR  = 8'h01;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;

  // x/10 == (x*205)>>11 for all 8-bit x
  localparam logic [7:0] RECIP_10    = 8'd205;
  localparam int         RECIP_SHIFT = 11;

  typedef enum logic [1:0] {
    OP_CHAR    = 2'd0,
    OP_DEC     = 2'd1,
    OP_REFRESH = 2'd2,
    OP_CLEAR   = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SCAN,
    ST_SCAN_DATA,
    ST_FLUSH
  } state_e;

  // one byte for the display bus
  typedef struct packed {
    logic       is_data;
    logic [7:0] bus_byte;
  } result_t;

endpackage

// ----- rtl/lcdsb_ram.sv -----
// lcdsb_ram: generic simple dual-port RAM, one write and one registered read port.
// Depends on nothing; no reset on the array or the read data.
module lcdsb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/lcd_shadow_buffer_refresh.sv -----
// lcd_shadow_buffer_refresh: top level, shadow cell RAM plus sequencer for writes,
// dirty-cell refresh and clear. Depends on lcdsb_pkg and lcdsb_ram.
//
//  channel   | handshake              | payload
//  ----------+------------------------+---------------------------------------
//  request   | start / busy           | opcode_i, char_value_i, column_i, row_i
//  result    | strobe_o (one cycle)   | is_data_o, bus_byte_o, last_of_run_o
//
// A decimal write also updates the tens cell, except at column 0; a clear's result
// comes on the next cycle; a refresh adds an ST_SCAN_DATA state per dirty cell.
// Each cycle the cell RAM takes at most one read and one write.
// Reset clears the per-cell valid bits; an unwritten cell reads as the fill
// byte (zero after reset, space after a clear), so no clearing pass is needed.
// No stalls: the last byte of a refresh goes out in the same cycle that busy falls.
module lcd_shadow_buffer_refresh #(
  parameter int COLUMNS = lcdsb_pkg::COLUMNS_DEF,
  parameter int ROWS    = lcdsb_pkg::ROWS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] opcode_i,
  input  logic [7:0] char_value_i,
  input  logic [3:0] column_i,
  input  logic       row_i,
  output logic       strobe_o,
  output logic       is_data_o,
  output logic [7:0] bus_byte_o,
  output logic       last_of_run_o
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int IDX_W = $clog2(CELLS);
  localparam int COL_W = $clog2(COLUMNS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CELLS - 1);
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);
  localparam logic [lcdsb_pkg::CNT_W-1:0] CNT_MAX =
    lcdsb_pkg::CNT_W'(lcdsb_pkg::MAX_CELLS_OUT);

  lcdsb_pkg::state_e  state_q, state_d;
  lcdsb_pkg::opcode_e op_in;

  logic accept, in_range;
  logic [IDX_W-1:0] in_addr;

  // request decode and digit split
  logic [15:0] prod;
  logic [4:0]  tens;
  logic [7:0]  units;
  logic [7:0]  tens_chr, units_chr;

  // datapath registers
  logic [IDX_W-1:0] addr_q, addr_d;
  logic [7:0]       cmp_q, cmp_d;
  logic [7:0]       tens_q, tens_d;
  logic             tens_pend_q, tens_pend_d;
  logic [COL_W-1:0] scan_col_q, scan_col_d;
  logic             scan_row_q, scan_row_d;
  logic [lcdsb_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [7:0]       data_q, data_d;
  logic [7:0]       fill_q, fill_d;
  logic [CELLS-1:0] valid_q, valid_d;
  logic             vld_rd_q;
  lcdsb_pkg::result_t pend_q, pend_d;
  logic             pend_vld_q, pend_vld_d;

  // output registers
  logic               out_stb_q, out_stb_d;
  lcdsb_pkg::result_t out_res_q, out_res_d;
  logic               out_last_q, out_last_d;

  // RAM port controls
  logic             rd_en, wr_en;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic [7:0]       wr_data, rd_data;
  logic [7:0]       eff;
  logic             dirty, scan_done;
  logic             produce;
  lcdsb_pkg::result_t new_res;

  lcdsb_ram #(
    .WIDTH (8),
    .DEPTH (CELLS)
  ) u_cells (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign accept   = start && (state_q == lcdsb_pkg::ST_IDLE);
  assign busy     = (state_q != lcdsb_pkg::ST_IDLE);
  assign op_in    = lcdsb_pkg::opcode_e'(opcode_i);
  assign in_range = (32'(row_i) < ROWS) && (32'(column_i) < COLUMNS);
  assign in_addr  = (row_i ? IDX_W'(COLUMNS) : '0) + IDX_W'(column_i);

  // value/10 by reciprocal, remainder by one multiply-subtract
  assign prod      = 16'(char_value_i) * 16'(lcdsb_pkg::RECIP_10);
  assign tens      = prod[15:lcdsb_pkg::RECIP_SHIFT];
  assign units     = char_value_i - 8'(8'(tens) * 8'd10);
  assign tens_chr  = 8'(tens) + lcdsb_pkg::CHAR_ZERO;
  assign units_chr = units + lcdsb_pkg::CHAR_ZERO;

  // cell as read: RAM data if ever written, else the fill byte
  assign eff       = vld_rd_q ? rd_data : fill_q;
  assign dirty     = eff[7];
  assign scan_done = (addr_q == LAST_IDX) || (cnt_q == CNT_MAX);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lcdsb_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (op_in)
            lcdsb_pkg::OP_CHAR,
            lcdsb_pkg::OP_DEC:     state_d = in_range ? lcdsb_pkg::ST_WRITE
                                                      : lcdsb_pkg::ST_IDLE;
            lcdsb_pkg::OP_REFRESH: state_d = lcdsb_pkg::ST_SCAN;
            lcdsb_pkg::OP_CLEAR:   state_d = lcdsb_pkg::ST_IDLE;
            default:               state_d = lcdsb_pkg::ST_IDLE;
          endcase
        end
      end
      lcdsb_pkg::ST_WRITE: begin
        state_d = tens_pend_q ? lcdsb_pkg::ST_WRITE : lcdsb_pkg::ST_IDLE;
      end
      lcdsb_pkg::ST_SCAN: begin
        if (dirty) begin
          state_d = lcdsb_pkg::ST_SCAN_DATA;
        end else if (addr_q == LAST_IDX) begin
          state_d = lcdsb_pkg::ST_FLUSH;
        end
      end
      lcdsb_pkg::ST_SCAN_DATA: begin
        state_d = scan_done ? lcdsb_pkg::ST_FLUSH : lcdsb_pkg::ST_SCAN;
      end
      lcdsb_pkg::ST_FLUSH: state_d = lcdsb_pkg::ST_IDLE;
      default:             state_d = lcdsb_pkg::ST_IDLE;
    endcase
  end

  // datapath and RAM controls per state
  always_comb begin
    rd_en       = 1'b0;
    rd_addr     = addr_q;
    wr_en       = 1'b0;
    wr_addr     = addr_q;
    wr_data     = cmp_q | lcdsb_pkg::DIRTY_BIT;
    produce     = 1'b0;
    new_res     = '{is_data: 1'b1, bus_byte: data_q};
    addr_d      = addr_q;
    cmp_d       = cmp_q;
    tens_d      = tens_q;
    tens_pend_d = tens_pend_q;
    scan_col_d  = scan_col_q;
    scan_row_d  = scan_row_q;
    cnt_d       = cnt_q;
    data_d      = data_q;
    fill_d      = fill_q;
    valid_d     = valid_q;
    out_stb_d   = 1'b0;
    out_res_d   = out_res_q;
    out_last_d  = 1'b0;

    unique case (state_q)
      lcdsb_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (op_in)
            lcdsb_pkg::OP_CHAR,
            lcdsb_pkg::OP_DEC: begin
              rd_en       = in_range;
              rd_addr     = in_addr;
              addr_d      = in_addr;
              cmp_d       = (op_in == lcdsb_pkg::OP_DEC) ? units_chr : char_value_i;
              tens_d      = tens_chr;
              tens_pend_d = (op_in == lcdsb_pkg::OP_DEC) && (column_i != 4'd0);
            end
            lcdsb_pkg::OP_REFRESH: begin
              rd_en      = 1'b1;
              rd_addr    = '0;
              addr_d     = '0;
              scan_col_d = '0;
              scan_row_d = 1'b0;
              cnt_d      = '0;
            end
            lcdsb_pkg::OP_CLEAR: begin
              // all cells become clean spaces at once
              fill_d     = lcdsb_pkg::CHAR_SPACE;
              valid_d    = '0;
              out_stb_d  = 1'b1;
              out_res_d  = '{is_data: 1'b0, bus_byte: lcdsb_pkg::CMD_CLEAR};
              out_last_d = 1'b1;
            end
            default: ;
          endcase
        end
      end

      // read-modify-write of one cell, then the tens cell if pending
      lcdsb_pkg::ST_WRITE: begin
        if (eff != cmp_q) begin
          wr_en            = 1'b1;
          valid_d[addr_q]  = 1'b1;
        end
        if (tens_pend_q) begin
          rd_en       = 1'b1;
          rd_addr     = addr_q - IDX_W'(1);
          addr_d      = addr_q - IDX_W'(1);
          cmp_d       = tens_q;
          tens_pend_d = 1'b0;
        end
      end

      lcdsb_pkg::ST_SCAN: begin
        if (dirty) begin
          // clear the mark, send the position command
          wr_en   = 1'b1;
          wr_data = eff & lcdsb_pkg::CHAR_MASK;
          valid_d[addr_q] = 1'b1;
          data_d  = eff & lcdsb_pkg::CHAR_MASK;
          cnt_d   = cnt_q + lcdsb_pkg::CNT_W'(1);
          produce = 1'b1;
          new_res = '{is_data: 1'b0,
                      bus_byte: (scan_row_q ? lcdsb_pkg::POS_ROW1 : lcdsb_pkg::POS_ROW0)
                                + 8'(scan_col_q)};
        end else if (addr_q != LAST_IDX) begin
          rd_en   = 1'b1;
          rd_addr = addr_q + IDX_W'(1);
        end
      end

      lcdsb_pkg::ST_SCAN_DATA: begin
        produce = 1'b1;
        if (!scan_done) begin
          rd_en   = 1'b1;
          rd_addr = addr_q + IDX_W'(1);
        end
      end

      lcdsb_pkg::ST_FLUSH: begin
        // the held-back result is the last of the run
        if (pend_vld_q) begin
          out_stb_d  = 1'b1;
          out_res_d  = pend_q;
          out_last_d = 1'b1;
        end
      end

      default: ;
    endcase

    // scan position advances with each new read
    if ((state_q == lcdsb_pkg::ST_SCAN || state_q == lcdsb_pkg::ST_SCAN_DATA) && rd_en) begin
      addr_d = addr_q + IDX_W'(1);
      if (scan_col_q == LAST_COL) begin
        scan_col_d = '0;
        scan_row_d = 1'b1;
      end else begin
        scan_col_d = scan_col_q + COL_W'(1);
      end
    end

    // hold back one result so the last one can be marked
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    if (produce) begin
      pend_d     = new_res;
      pend_vld_d = 1'b1;
      if (pend_vld_q) begin
        out_stb_d = 1'b1;
        out_res_d = pend_q;
      end
    end
    if (state_q == lcdsb_pkg::ST_FLUSH) begin
      pend_vld_d = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lcdsb_pkg::ST_IDLE;
      tens_pend_q <= 1'b0;
      cnt_q       <= '0;
      fill_q      <= '0;
      valid_q     <= '0;
      pend_vld_q  <= 1'b0;
      out_stb_q   <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      tens_pend_q <= tens_pend_d;
      cnt_q       <= cnt_d;
      fill_q      <= fill_d;
      valid_q     <= valid_d;
      pend_vld_q  <= pend_vld_d;
      out_stb_q   <= out_stb_d;
      out_last_q  <= out_last_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    addr_q     <= addr_d;
    cmp_q      <= cmp_d;
    tens_q     <= tens_d;
    scan_col_q <= scan_col_d;
    scan_row_q <= scan_row_d;
    data_q     <= data_d;
    pend_q     <= pend_d;
    out_res_q  <= out_res_d;
    if (rd_en) begin
      vld_rd_q <= valid_q[rd_addr];
    end
  end

  assign strobe_o      = out_stb_q;
  assign is_data_o     = out_res_q.is_data;
  assign bus_byte_o    = out_res_q.bus_byte;
  assign last_of_run_o = out_last_q;

  // no result may stay held back once the sequencer is idle
  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lcdsb_pkg::ST_IDLE) |-> !pend_vld_q)
    else $error("held-back result left while idle");

  // an accepted clear answers with the clear command on the next cycle
  a_clear_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op_in == lcdsb_pkg::OP_CLEAR) |=>
      (strobe_o && !is_data_o && last_of_run_o && bus_byte_o == lcdsb_pkg::CMD_CLEAR))
    else $error("clear command not issued");

  // a position command is always followed by its data byte
  a_pos_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && !is_data_o && bus_byte_o != lcdsb_pkg::CMD_CLEAR) |-> !last_of_run_o)
    else $error("position command marked last");

  // a refresh never sends more cells than the run limit
  a_cnt_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lcdsb_pkg::ST_SCAN && dirty) |-> (cnt_q < CNT_MAX))
    else $error("refresh exceeded its cell limit");

endmodule

// ----- verif/lcd_shadow_buffer_refresh_tb.sv -----
// Testbench for lcd_shadow_buffer_refresh: drives write, decimal, refresh and clear
// requests, predicts the display bus bytes and checks them. Depends on lcdsb_pkg.
`timescale 1ns / 100ps

module lcd_shadow_buffer_refresh_tb;

  localparam int NCOLS       = lcdsb_pkg::COLUMNS_DEF;
  localparam int NROWS       = lcdsb_pkg::ROWS_DEF;
  localparam int NCELLS      = NCOLS * NROWS;
  localparam int RANDOM_REQS = 284;

  // one byte on the display bus as the block should emit it
  typedef struct packed {
    logic       is_data;
    logic [7:0] bus_byte;
    logic       last_of_run;
  } bus_word_t;

  // shadow copy of the cell store plus the bus bytes still owed
  class shadow_scoreboard;
    logic [7:0] shadow_cells[NCELLS];
    bus_word_t  expected_bytes[$];
    int         mismatches;

    function new();
      foreach (shadow_cells[i]) shadow_cells[i] = 8'h00;
      mismatches = 0;
    endfunction

    // one line per mismatch, and count it
    task report_mismatch(string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      mismatches++;
    endtask

    function logic [7:0] cell_at(int r, int c);
      return shadow_cells[r * NCOLS + c];
    endfunction

    // only a changed byte is stored, and then it is marked dirty
    function void put_cell(int r, int c, logic [7:0] v);
      int idx;
      idx = r * NCOLS + c;
      if (shadow_cells[idx] != v) shadow_cells[idx] = v | lcdsb_pkg::DIRTY_BIT;
    endfunction

    function void note_request(lcdsb_pkg::opcode_e op, logic [7:0] val, logic [3:0] col,
                               logic row);
      bus_word_t run[$];
      bus_word_t w;
      int        idx;
      case (op)
        lcdsb_pkg::OP_CHAR: begin
          if (row < NROWS && col < NCOLS) put_cell(row, col, val);
        end
        lcdsb_pkg::OP_DEC: begin
          if (row < NROWS && col < NCOLS) begin
            put_cell(row, col, 8'(val % 10) + lcdsb_pkg::CHAR_ZERO);
            // no tens digit left of column zero
            if (col > 0) put_cell(row, col - 1, 8'(val / 10) + lcdsb_pkg::CHAR_ZERO);
          end
        end
        lcdsb_pkg::OP_REFRESH: begin
          // row-major scan, capped at MAX_RESULTS bytes per request
          for (int r = 0; r < NROWS; r++) begin
            for (int c = 0; c < NCOLS; c++) begin
              idx = r * NCOLS + c;
              if (run.size() + 2 <= lcdsb_pkg::MAX_RESULTS && shadow_cells[idx][7]) begin
                shadow_cells[idx] = shadow_cells[idx] & lcdsb_pkg::CHAR_MASK;
                w.is_data     = 1'b0;
                w.bus_byte    = (r == 0 ? lcdsb_pkg::POS_ROW0 : lcdsb_pkg::POS_ROW1) + 8'(c);
                w.last_of_run = 1'b0;
                run.push_back(w);
                w.is_data  = 1'b1;
                w.bus_byte = shadow_cells[idx];
                run.push_back(w);
              end
            end
          end
        end
        default: begin
          w.is_data     = 1'b0;
          w.bus_byte    = lcdsb_pkg::CMD_CLEAR;
          w.last_of_run = 1'b0;
          run.push_back(w);
          foreach (shadow_cells[i]) shadow_cells[i] = lcdsb_pkg::CHAR_SPACE;
        end
      endcase
      if (run.size() > 0) begin
        w = run.pop_back();
        w.last_of_run = 1'b1;
        run.push_back(w);
      end
      foreach (run[i]) expected_bytes.push_back(run[i]);
    endfunction

    task check_byte(logic is_data, logic [7:0] bus_byte, logic last_of_run);
      bus_word_t w;
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected byte rs=%b byte=%02h last=%b",
                                  is_data, bus_byte, last_of_run));
        return;
      end
      w = expected_bytes.pop_front();
      if (is_data !== w.is_data)
        report_mismatch($sformatf("is_data %b, expected %b", is_data, w.is_data));
      if (bus_byte !== w.bus_byte)
        report_mismatch($sformatf("bus_byte %02h, expected %02h", bus_byte, w.bus_byte));
      if (last_of_run !== w.last_of_run)
        report_mismatch($sformatf("last_of_run %b, expected %b",
                                  last_of_run, w.last_of_run));
    endtask
  endclass

  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic       start        = 1'b0;
  logic [1:0] opcode_i     = lcdsb_pkg::OP_CHAR;
  logic [7:0] char_value_i = 8'h00;
  logic [3:0] column_i     = 4'h0;
  logic       row_i        = 1'b0;
  logic       busy;
  logic       strobe_o;
  logic       is_data_o;
  logic [7:0] bus_byte_o;
  logic       last_of_run_o;

  shadow_scoreboard sb;
  bit               no_idle = 1'b0;

  lcd_shadow_buffer_refresh u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .opcode_i     (opcode_i),
    .char_value_i (char_value_i),
    .column_i     (column_i),
    .row_i        (row_i),
    .strobe_o     (strobe_o),
    .is_data_o    (is_data_o),
    .bus_byte_o   (bus_byte_o),
    .last_of_run_o(last_of_run_o)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // every strobed byte is checked against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && strobe_o === 1'b1) sb.check_byte(is_data_o, bus_byte_o, last_of_run_o);
  end

  // optional idle gap, then hold the request until the block takes it
  task send_request(lcdsb_pkg::opcode_e op, logic [7:0] val, logic [3:0] col, logic row);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start        <= 1'b1;
    opcode_i     <= op;
    char_value_i <= val;
    column_i     <= col;
    row_i        <= row;
    do @(posedge clk_i); while (busy !== 1'b0);
    sb.note_request(op, val, col, row);
  endtask

  // mostly writes; some values repeat the stored byte to hit the no-change path
  task random_request();
    int                 pick;
    lcdsb_pkg::opcode_e op;
    logic [7:0]         val;
    logic [3:0]         col;
    logic               row;
    pick = $urandom_range(0, 99);
    col  = $urandom_range(0, 15);
    row  = $urandom_range(0, 1);
    val  = $urandom_range(0, 255);
    if (pick < 45) op = lcdsb_pkg::OP_CHAR;
    else if (pick < 75) op = lcdsb_pkg::OP_DEC;
    else if (pick < 93) op = lcdsb_pkg::OP_REFRESH;
    else op = lcdsb_pkg::OP_CLEAR;
    case ($urandom_range(0, 9))
      0, 1: val = sb.cell_at(row, col);
      2: val = sb.cell_at(row, col) & lcdsb_pkg::CHAR_MASK;
      3: val = $urandom_range(0, 1) ? 8'hff : 8'h00;
      default: ;
    endcase
    send_request(op, val, col, row);
  endtask

  // main sequence
  initial begin
    int waited;
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty refresh, unchanged writes, bit 7 set, tens at column zero
    send_request(lcdsb_pkg::OP_REFRESH, 8'h00, 4'd0, 1'b0);
    send_request(lcdsb_pkg::OP_CHAR, 8'h00, 4'd0, 1'b0);
    send_request(lcdsb_pkg::OP_CHAR, 8'hff, 4'd15, 1'b1);
    send_request(lcdsb_pkg::OP_CHAR, 8'hff, 4'd15, 1'b1);
    send_request(lcdsb_pkg::OP_DEC, 8'd255, 4'd0, 1'b0);
    send_request(lcdsb_pkg::OP_DEC, 8'd99, 4'd15, 1'b1);
    send_request(lcdsb_pkg::OP_REFRESH, 8'h00, 4'd0, 1'b0);
    send_request(lcdsb_pkg::OP_CLEAR, 8'h00, 4'd0, 1'b0);
    send_request(lcdsb_pkg::OP_CHAR, lcdsb_pkg::CHAR_SPACE, 4'd7, 1'b0);
    // dirty every cell, then one refresh drains the full 64 bytes
    for (int k = 0; k < 16; k++)
      send_request(lcdsb_pkg::OP_DEC, 8'(k * 17), 4'(2 * (k % 8) + 1), 1'(k / 8));
    send_request(lcdsb_pkg::OP_REFRESH, 8'h00, 4'd0, 1'b0);

    // random part, with runs of back-to-back requests
    for (int i = 0; i < RANDOM_REQS; i++) begin
      if (i % 32 == 0) no_idle = ($urandom_range(0, 3) == 0);
      random_request();
    end
    start <= 1'b0;

    // drain, then allow for stray bytes
    waited = 0;
    while (sb.expected_bytes.size() > 0 && waited < 2000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (80) @(posedge clk_i);
    if (sb.expected_bytes.size() > 0)
      sb.report_mismatch($sformatf("%0d bytes never arrived", sb.expected_bytes.size()));

    if (sb.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // hang guard
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
